[hdl/pfd_pkg.sv]
// Shared widths, configuration record and datapath control types for the PID block.
package pfd_pkg;

    localparam int DATA_W     = 16;
    localparam int FRAC_BITS  = 8;
    localparam int GAIN_W     = 16;
    localparam int TAU_W      = 16;
    localparam int PERIOD_W   = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = (DATA_W > GAIN_W) ? DATA_W : GAIN_W;
    localparam int CLAMP_W    = 2;

    localparam int S_TDATA_W = ((2 * DATA_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DATA_W + CLAMP_W + 7) / 8) * 8;

    // Datapath widths, derived from the field widths above except the fixed DACC_W.
    localparam int ERR_W   = DATA_W + 1;
    localparam int ESUM_W  = ERR_W + 1;
    localparam int PROP_W  = GAIN_W + ERR_W;
    localparam int KIDT_W  = GAIN_W + PERIOD_W + 1;
    localparam int IPROD_W = KIDT_W + ESUM_W;
    localparam int ISUM_W  = IPROD_W + 1;
    localparam int INTEG_W = DATA_W + FRAC_BITS + 1;
    localparam int KDDM_W  = GAIN_W + ERR_W;
    localparam int DEN_W   = ((TAU_W + 1 > PERIOD_W + FRAC_BITS) ?
                              TAU_W + 1 : PERIOD_W + FRAC_BITS) + 1;
    localparam int DACC_W  = 32;
    localparam int CTD_W   = DEN_W + DACC_W;
    localparam int NUM_W   = ((KDDM_W + FRAC_BITS + 1 > CTD_W) ?
                              KDDM_W + FRAC_BITS + 1 : CTD_W) + 1;
    localparam int QUO_W   = NUM_W + (NUM_W % 2);
    localparam int DIV_ITERS = QUO_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_ITERS);
    localparam int SUM_W   = ((PROP_W > DACC_W) ? PROP_W : DACC_W) + 2;
    localparam int MUL_A_W = (KIDT_W > DEN_W) ? KIDT_W : DEN_W;
    localparam int MUL_B_W = (DACC_W > ESUM_W) ? DACC_W : ESUM_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam logic [GAIN_W-1:0]   GAIN_P_RESET = GAIN_W'(256);
    localparam logic [GAIN_W-1:0]   GAIN_I_RESET = '0;
    localparam logic [GAIN_W-1:0]   GAIN_D_RESET = '0;
    localparam logic [TAU_W-1:0]    TAU_RESET    = TAU_W'(256);
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1);
    localparam logic [DATA_W-1:0]   LIMIT_HIGH_RESET = {1'b0, {(DATA_W - 1){1'b1}}};
    localparam logic [DATA_W-1:0]   LIMIT_LOW_RESET  = {1'b1, {(DATA_W - 1){1'b0}}};

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic [TAU_W-1:0]         filter_tau;
        logic [PERIOD_W-1:0]      sample_period;
        logic signed [DATA_W-1:0] limit_high;
        logic signed [DATA_W-1:0] limit_low;
    } cfg_t;

    typedef enum logic [CLAMP_W-1:0] {
        CLAMP_NONE = 2'd0,
        CLAMP_HIGH = 2'd1,
        CLAMP_LOW  = 2'd2
    } clamp_t;

    typedef enum logic [3:0] {
        ALU_NOP,
        ALU_LOAD,
        ALU_DIFF,
        ALU_SAVE_P,
        ALU_INTEG_ADD,
        ALU_NUM_KD,
        ALU_NUM_ADD,
        ALU_INTEG_CLAMP,
        ALU_DIV_INIT,
        ALU_DIV_STEP,
        ALU_DIV_DONE,
        ALU_DERIV_ZERO,
        ALU_SUM,
        ALU_ROUND,
        ALU_EMIT
    } alu_op_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_KP_ERR,
        MUL_KI_DT,
        MUL_KIDT_ESUM,
        MUL_KD_DM,
        MUL_CT_DACC
    } mul_sel_t;

    typedef struct packed {
        alu_op_t  alu;
        mul_sel_t mul;
    } uop_t;

    typedef struct packed {
        logic den_zero;
        logic div_more;
    } dp_status_t;

endpackage

[hdl/pfd_datapath.sv]
// Arithmetic datapath of the PID block: one shared multiplier, accumulators and a radix-4 divider.
module pfd_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  pfd_pkg::uop_t                    op,
    input  pfd_pkg::cfg_t                    cfg,
    input  logic signed [pfd_pkg::DATA_W-1:0] in_meas,
    input  logic signed [pfd_pkg::DATA_W-1:0] in_tgt,
    output pfd_pkg::dp_status_t              status,
    output logic signed [pfd_pkg::DATA_W-1:0] drive,
    output pfd_pkg::clamp_t                  clamp_state
);
    import pfd_pkg::*;

    localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [DACC_W-1:0] DACC_MAX = {1'b0, {(DACC_W - 1){1'b1}}};
    localparam logic signed [DACC_W-1:0] DACC_MIN = {1'b1, {(DACC_W - 1){1'b0}}};

    logic signed [DATA_W-1:0]  meas_reg, meas_next, tgt_reg, tgt_next;
    logic signed [ERR_W-1:0]   err_reg, err_next, dm_reg, dm_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [PROP_W-1:0]  p_reg, p_next;
    logic signed [ISUM_W-1:0]  isum_reg, isum_next;
    logic signed [INTEG_W-1:0] integ_reg, integ_next;
    logic signed [NUM_W-1:0]   num_reg, num_next;
    logic                      num_neg_reg, num_neg_next;
    logic [DEN_W-1:0]          den_reg, den_next, rem_reg, rem_next;
    logic [QUO_W-1:0]          dvd_reg, dvd_next;
    logic [DIV_CNT_W-1:0]      cnt_reg, cnt_next;
    logic signed [DACC_W-1:0]  deriv_reg, deriv_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic signed [DATA_W-1:0]  drive_reg, drive_next;
    clamp_t                    clamp_reg, clamp_next;
    logic signed [ERR_W-1:0]   last_err_reg, last_err_next;
    logic signed [DATA_W-1:0]  last_meas_reg, last_meas_next;

    logic signed [ESUM_W-1:0]  esum;
    logic [DEN_W-1:0]          tau2, dtq, den;
    logic signed [DEN_W-1:0]   ct;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [IPROD_W-1:0] iprod, ihalf_s;
    logic [IPROD_W-1:0]        imag, ihalf;
    logic signed [ISUM_W-1:0]  hi_isum, lo_isum;
    logic signed [SUM_W-1:0]   hi_sum, lo_sum;
    logic [NUM_W-1:0]          num_mag;
    logic [DEN_W:0]            r1, r2;
    logic [DEN_W-1:0]          r1s, r2s;
    logic                      ge1, ge2;
    logic [QUO_W-1:0]          d1, d2;
    logic                      q_big_pos, q_big_neg;
    logic signed [DACC_W-1:0]  deriv_sat;
    logic [SUM_W-1:0]          smag, sround;
    logic signed [DATA_W-1:0]  drive_rnd;

    // Operands that several steps share.
    always_comb begin
        esum    = ESUM_W'(err_reg) + ESUM_W'(last_err_reg);
        tau2    = DEN_W'({cfg.filter_tau, 1'b0});
        dtq     = DEN_W'(cfg.sample_period) << FRAC_BITS;
        den     = tau2 + dtq;
        ct      = $signed(tau2 - dtq);
        hi_isum = ISUM_W'($signed(cfg.limit_high)) <<< FRAC_BITS;
        lo_isum = ISUM_W'($signed(cfg.limit_low)) <<< FRAC_BITS;
        hi_sum  = SUM_W'($signed(cfg.limit_high)) <<< FRAC_BITS;
        lo_sum  = SUM_W'($signed(cfg.limit_low)) <<< FRAC_BITS;
    end

    // Shared multiplier; the product is registered before any use.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (op.mul)
            MUL_KP_ERR: begin
                mul_a = MUL_A_W'($signed(cfg.gain_p));
                mul_b = MUL_B_W'(err_reg);
            end
            MUL_KI_DT: begin
                mul_a = MUL_A_W'($signed(cfg.gain_i));
                mul_b = MUL_B_W'($signed({1'b0, cfg.sample_period}));
            end
            MUL_KIDT_ESUM: begin
                mul_a = MUL_A_W'($signed(prod_reg[KIDT_W-1:0]));
                mul_b = MUL_B_W'(esum);
            end
            MUL_KD_DM: begin
                mul_a = MUL_A_W'($signed(cfg.gain_d));
                mul_b = MUL_B_W'(dm_reg);
            end
            MUL_CT_DACC: begin
                mul_a = MUL_A_W'(ct);
                mul_b = MUL_B_W'(deriv_reg);
            end
            default: begin
            end
        endcase
        prod_next = (op.mul != MUL_NONE) ? PROD_W'(mul_a * mul_b) : prod_reg;
    end

    // Integrator increment: halve with rounding to nearest, ties away from zero.
    always_comb begin
        iprod   = $signed(prod_reg[IPROD_W-1:0]);
        imag    = iprod[IPROD_W-1] ? IPROD_W'(-iprod) : IPROD_W'(iprod);
        ihalf   = (imag + IPROD_W'(1)) >> 1;
        ihalf_s = iprod[IPROD_W-1] ? -$signed(ihalf) : $signed(ihalf);
    end

    // Two restoring divide steps per cycle.
    always_comb begin
        num_mag = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
        r1  = {rem_reg, dvd_reg[QUO_W-1]};
        ge1 = r1 >= {1'b0, den_reg};
        r1s = ge1 ? DEN_W'(r1 - {1'b0, den_reg}) : DEN_W'(r1);
        d1  = {dvd_reg[QUO_W-2:0], ge1};
        r2  = {r1s, d1[QUO_W-1]};
        ge2 = r2 >= {1'b0, den_reg};
        r2s = ge2 ? DEN_W'(r2 - {1'b0, den_reg}) : DEN_W'(r2);
        d2  = {d1[QUO_W-2:0], ge2};
    end

    // The derivative is the negated quotient, saturated to 32 bits.
    always_comb begin
        q_big_pos = |dvd_reg[QUO_W-1:DACC_W-1];
        q_big_neg = (|dvd_reg[QUO_W-1:DACC_W]) ||
                    (dvd_reg[DACC_W-1] && (|dvd_reg[DACC_W-2:0]));
        if (num_neg_reg) begin
            deriv_sat = q_big_pos ? DACC_MAX : $signed(dvd_reg[DACC_W-1:0]);
        end else begin
            deriv_sat = q_big_neg ? DACC_MIN : -$signed(dvd_reg[DACC_W-1:0]);
        end
    end

    always_comb begin
        smag      = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        sround    = (smag + ROUND_HALF) >> FRAC_BITS;
        drive_rnd = sum_reg[SUM_W-1] ? -$signed(sround[DATA_W-1:0])
                                     : $signed(sround[DATA_W-1:0]);
    end

    always_comb begin
        meas_next      = meas_reg;
        tgt_next       = tgt_reg;
        err_next       = err_reg;
        dm_next        = dm_reg;
        p_next         = p_reg;
        isum_next      = isum_reg;
        integ_next     = integ_reg;
        num_next       = num_reg;
        num_neg_next   = num_neg_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        cnt_next       = cnt_reg;
        deriv_next     = deriv_reg;
        sum_next       = sum_reg;
        drive_next     = drive_reg;
        clamp_next     = clamp_reg;
        last_err_next  = last_err_reg;
        last_meas_next = last_meas_reg;
        case (op.alu)
            ALU_LOAD: begin
                meas_next = in_meas;
                tgt_next  = in_tgt;
            end
            ALU_DIFF: begin
                err_next = ERR_W'(tgt_reg) - ERR_W'(meas_reg);
                dm_next  = ERR_W'(meas_reg) - ERR_W'(last_meas_reg);
            end
            ALU_SAVE_P: begin
                p_next = $signed(prod_reg[PROP_W-1:0]);
            end
            ALU_INTEG_ADD: begin
                isum_next = ISUM_W'(integ_reg) + ISUM_W'(ihalf_s);
            end
            ALU_NUM_KD: begin
                num_next = NUM_W'($signed(prod_reg[KDDM_W-1:0])) <<< (FRAC_BITS + 1);
            end
            ALU_NUM_ADD: begin
                num_next = num_reg + NUM_W'($signed(prod_reg[CTD_W-1:0]));
            end
            ALU_INTEG_CLAMP: begin
                // Upper limit tested first; if inverted, values above it get high, all others low.
                if (isum_reg > hi_isum) begin
                    integ_next = INTEG_W'(hi_isum);
                end else if (isum_reg < lo_isum) begin
                    integ_next = INTEG_W'(lo_isum);
                end else begin
                    integ_next = INTEG_W'(isum_reg);
                end
            end
            ALU_DIV_INIT: begin
                // Adding half the divisor up front turns truncation into rounding.
                den_next     = den;
                rem_next     = '0;
                num_neg_next = num_reg[NUM_W-1];
                dvd_next     = QUO_W'(num_mag) + QUO_W'(den >> 1);
                cnt_next     = DIV_CNT_W'(DIV_ITERS - 1);
            end
            ALU_DIV_STEP: begin
                rem_next = r2s;
                dvd_next = d2;
                cnt_next = cnt_reg - 1'b1;
            end
            ALU_DIV_DONE: begin
                deriv_next = deriv_sat;
            end
            ALU_DERIV_ZERO: begin
                deriv_next = '0;
            end
            ALU_SUM: begin
                sum_next = SUM_W'(p_reg) + SUM_W'(integ_reg) + SUM_W'(deriv_reg);
            end
            ALU_ROUND: begin
                if (sum_reg > hi_sum) begin
                    drive_next = cfg.limit_high;
                    clamp_next = CLAMP_HIGH;
                end else if (sum_reg < lo_sum) begin
                    drive_next = cfg.limit_low;
                    clamp_next = CLAMP_LOW;
                end else begin
                    drive_next = drive_rnd;
                    clamp_next = CLAMP_NONE;
                end
            end
            ALU_EMIT: begin
                last_err_next  = err_reg;
                last_meas_next = meas_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg     <= '0;
            deriv_reg     <= '0;
            last_err_reg  <= '0;
            last_meas_reg <= '0;
            cnt_reg       <= '0;
        end else begin
            integ_reg     <= integ_next;
            deriv_reg     <= deriv_next;
            last_err_reg  <= last_err_next;
            last_meas_reg <= last_meas_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        meas_next_hold: begin
        end
        meas_reg    <= meas_next;
        tgt_reg     <= tgt_next;
        err_reg     <= err_next;
        dm_reg      <= dm_next;
        prod_reg    <= prod_next;
        p_reg       <= p_next;
        isum_reg    <= isum_next;
        num_reg     <= num_next;
        num_neg_reg <= num_neg_next;
        den_reg     <= den_next;
        rem_reg     <= rem_next;
        dvd_reg     <= dvd_next;
        sum_reg     <= sum_next;
        drive_reg   <= drive_next;
        clamp_reg   <= clamp_next;
    end

    assign status.den_zero = (den == '0);
    assign status.div_more = (cnt_reg != '0);
    assign drive           = drive_reg;
    assign clamp_state     = clamp_reg;

endmodule

[hdl/pid_filtered_derivative_top.sv]
// PID step with trapezoidal integrator and Tustin-filtered derivative, microcoded control.
//
// Usage: each request on the s_ channel carries one measurement and one setpoint;
// the block answers with one request on the m_ channel carrying the drive value
// and the clamp state. Gains, filter time constant, sample period and limits are
// written through cfg_wr_en / cfg_addr / cfg_wr_data, by the user only while no item
// is in flight; the block itself does not enforce this.
//
// When filter_tau and sample_period are both zero, the divider is skipped and the
// derivative is zero. s_tready is high only while the sequencer sits in its idle
// step, so a new item is taken only once the last one reaches the output register.
// The divider retires two quotient bits per cycle; the other steps share one multiplier.
//
// Reset (aresetn low at a clock edge) restores the register defaults, clears the
// integrator, derivative, previous error and previous measurement, and drops
// m_tvalid. When the receiver stalls, the finished result stays in the output
// register; the next item is accepted meanwhile and its computation waits in the
// step before the output register until that register is free.
module pid_filtered_derivative_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // Fields from bit 0 up: measured[15:0], target[31:16].
    input  logic [pfd_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // Fields from bit 0 up: drive[15:0], clamp_state[17:16], zero fill[23:18].
    output logic [pfd_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [pfd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [pfd_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);
    import pfd_pkg::*;

    localparam int STEP_W = 5;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t S_IDLE       = 5'd0;
    localparam step_t S_DIFF       = 5'd1;
    localparam step_t S_MUL_P      = 5'd2;
    localparam step_t S_MUL_KIDT   = 5'd3;
    localparam step_t S_MUL_INTEG  = 5'd4;
    localparam step_t S_INTEG_ADD  = 5'd5;
    localparam step_t S_KD_SAVE    = 5'd6;
    localparam step_t S_NUM_ADD    = 5'd7;
    localparam step_t S_CLAMP      = 5'd8;
    localparam step_t S_DIV_INIT   = 5'd9;
    localparam step_t S_DIV_LOOP   = 5'd10;
    localparam step_t S_DIV_DONE   = 5'd11;
    localparam step_t S_DERIV_ZERO = 5'd12;
    localparam step_t S_SUM        = 5'd13;
    localparam step_t S_ROUND      = 5'd14;
    localparam step_t S_WAIT_OUT   = 5'd15;
    localparam step_t S_EMIT       = 5'd16;

    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_P        = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_I        = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_D        = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_FILTER_TAU    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_PERIOD = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_LIMIT_HIGH    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_LIMIT_LOW     = 3'd6;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_DEN_ZERO,
        COND_DIV_MORE,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        uop_t  op;
        cond_t cond;
        step_t target;
    } ucode_t;

    function automatic ucode_t uc(input alu_op_t alu, input mul_sel_t mul,
                                  input cond_t cond, input step_t target);
        ucode_t w;
        w.op.alu  = alu;
        w.op.mul  = mul;
        w.cond    = cond;
        w.target  = target;
        return w;
    endfunction

    // Control store: one word per step; a true condition jumps, otherwise the
    // step counter advances by one.
    function automatic ucode_t ucode_rom(input step_t s);
        ucode_t w;
        case (s)
            S_IDLE:       w = uc(ALU_LOAD,        MUL_NONE,      COND_NO_INPUT, S_IDLE);
            S_DIFF:       w = uc(ALU_DIFF,        MUL_NONE,      COND_NEVER,    S_IDLE);
            S_MUL_P:      w = uc(ALU_NOP,         MUL_KP_ERR,    COND_NEVER,    S_IDLE);
            S_MUL_KIDT:   w = uc(ALU_SAVE_P,      MUL_KI_DT,     COND_NEVER,    S_IDLE);
            S_MUL_INTEG:  w = uc(ALU_NOP,         MUL_KIDT_ESUM, COND_NEVER,    S_IDLE);
            S_INTEG_ADD:  w = uc(ALU_INTEG_ADD,   MUL_KD_DM,     COND_NEVER,    S_IDLE);
            S_KD_SAVE:    w = uc(ALU_NUM_KD,      MUL_CT_DACC,   COND_NEVER,    S_IDLE);
            S_NUM_ADD:    w = uc(ALU_NUM_ADD,     MUL_NONE,      COND_NEVER,    S_IDLE);
            S_CLAMP:      w = uc(ALU_INTEG_CLAMP, MUL_NONE,      COND_NEVER,    S_IDLE);
            S_DIV_INIT:   w = uc(ALU_DIV_INIT,    MUL_NONE,      COND_DEN_ZERO, S_DERIV_ZERO);
            S_DIV_LOOP:   w = uc(ALU_DIV_STEP,    MUL_NONE,      COND_DIV_MORE, S_DIV_LOOP);
            S_DIV_DONE:   w = uc(ALU_DIV_DONE,    MUL_NONE,      COND_ALWAYS,   S_SUM);
            S_DERIV_ZERO: w = uc(ALU_DERIV_ZERO,  MUL_NONE,      COND_NEVER,    S_IDLE);
            S_SUM:        w = uc(ALU_SUM,         MUL_NONE,      COND_NEVER,    S_IDLE);
            S_ROUND:      w = uc(ALU_ROUND,       MUL_NONE,      COND_NEVER,    S_IDLE);
            S_WAIT_OUT:   w = uc(ALU_NOP,         MUL_NONE,      COND_OUT_BUSY, S_WAIT_OUT);
            S_EMIT:       w = uc(ALU_EMIT,        MUL_NONE,      COND_ALWAYS,   S_IDLE);
            default:      w = uc(ALU_NOP,         MUL_NONE,      COND_ALWAYS,   S_IDLE);
        endcase
        return w;
    endfunction

    step_t                 step_reg, step_next;
    ucode_t                word;
    logic                  jump;
    cfg_t                  cfg_reg, cfg_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;
    dp_status_t            status;
    logic signed [DATA_W-1:0] dp_drive;
    clamp_t                dp_clamp;

    assign word = ucode_rom(step_reg);

    always_comb begin
        case (word.cond)
            COND_NEVER:    jump = 1'b0;
            COND_ALWAYS:   jump = 1'b1;
            COND_NO_INPUT: jump = !s_tvalid;
            COND_DEN_ZERO: jump = status.den_zero;
            COND_DIV_MORE: jump = status.div_more;
            COND_OUT_BUSY: jump = m_tvalid_reg && !m_tready;
            default:       jump = 1'b1;
        endcase
        step_next = jump ? word.target : STEP_W'(step_reg + 1'b1);
    end

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_GAIN_P:        cfg_next.gain_p        = cfg_wr_data[GAIN_W-1:0];
                REG_GAIN_I:        cfg_next.gain_i        = cfg_wr_data[GAIN_W-1:0];
                REG_GAIN_D:        cfg_next.gain_d        = cfg_wr_data[GAIN_W-1:0];
                REG_FILTER_TAU:    cfg_next.filter_tau    = cfg_wr_data[TAU_W-1:0];
                REG_SAMPLE_PERIOD: cfg_next.sample_period = cfg_wr_data[PERIOD_W-1:0];
                REG_LIMIT_HIGH:    cfg_next.limit_high    = cfg_wr_data[DATA_W-1:0];
                REG_LIMIT_LOW:     cfg_next.limit_low     = cfg_wr_data[DATA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The output register frees itself on a taken request and refills at the emit step.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (word.op.alu == ALU_EMIT) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = M_TDATA_W'({dp_clamp, dp_drive});
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg              <= S_IDLE;
            m_tvalid_reg          <= 1'b0;
            cfg_reg.gain_p        <= GAIN_P_RESET;
            cfg_reg.gain_i        <= GAIN_I_RESET;
            cfg_reg.gain_d        <= GAIN_D_RESET;
            cfg_reg.filter_tau    <= TAU_RESET;
            cfg_reg.sample_period <= PERIOD_RESET;
            cfg_reg.limit_high    <= LIMIT_HIGH_RESET;
            cfg_reg.limit_low     <= LIMIT_LOW_RESET;
        end else begin
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
            cfg_reg      <= cfg_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    pfd_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .op          (word.op),
        .cfg         (cfg_reg),
        .in_meas     ($signed(s_tdata[DATA_W-1:0])),
        .in_tgt      ($signed(s_tdata[2*DATA_W-1:DATA_W])),
        .status      (status),
        .drive       (dp_drive),
        .clamp_state (dp_clamp)
    );

    assign s_tready = (step_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
